/* rtl/mcd_pkg.sv */
// shared types, codes and the direction shuffle for the maze carver
package mcd_pkg;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_STEP  = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      EV_STARTED     = 3'd0,
      EV_CARVED      = 3'd1,
      EV_BLOCKED     = 3'd2,
      EV_BACKTRACKED = 3'd3,
      EV_FINISHED    = 3'd4,
      EV_READ        = 3'd5
   } event_type;

   typedef enum logic [1:0] {
      DIR_UP    = 2'd0,
      DIR_DOWN  = 2'd1,
      DIR_LEFT  = 2'd2,
      DIR_RIGHT = 2'd3
   } dir_type;

   // where the reported cell comes from
   typedef enum logic [1:0] {
      POS_REQ  = 2'd0,
      POS_TOP  = 2'd1,
      POS_TGT  = 2'd2,
      POS_ZERO = 2'd3
   } pos_type;

   typedef enum logic [2:0] {
      ST_INIT_CLR  = 3'd0,
      ST_IDLE      = 3'd1,
      ST_START_CLR = 3'd2,
      ST_START_FIN = 3'd3,
      ST_STEP_DEC  = 3'd4,
      ST_STEP_MID  = 3'd5,
      ST_POP_LD    = 3'd6,
      ST_READ_RSP  = 3'd7
   } state_type;

   typedef struct packed {
      logic      latch_req;
      logic      rd_req;
      logic      clr_reset;
      logic      clr_write;
      logic      start_open;
      logic      start_empty;
      logic      carve;
      logic      mid_write;
      logic      blocked;
      logic      pop;
      logic      pop_load;
      logic      emit;
      event_type ev;
      pos_type   pos;
   } ctrl_cmd_type;

   typedef struct packed {
      logic level_zero;
      logic top_done;
      logic pop_more;
      logic step_ok;
      logic clr_last;
      logic start_inside;
   } ctrl_sts_type;

   // order starts 0,1,2,3; entry i swaps with entry bits[2i+1:2i]
   function automatic logic [7:0] shuffle_order(input logic [7:0] bits);
      logic [1:0] ord [4];
      logic [1:0] t;
      logic [1:0] tmp;
      logic [7:0] res;
      for (int i = 0; i < 4; i++) begin
         ord[i] = 2'(i);
      end
      for (int i = 0; i < 4; i++) begin
         t      = bits[2*i +: 2];
         tmp    = ord[i];
         ord[i] = ord[t];
         ord[t] = tmp;
      end
      for (int i = 0; i < 4; i++) begin
         res[2*i +: 2] = ord[i];
      end
      return res;
   endfunction

endpackage

/* rtl/maze_carver_dfs.sv */
// top level of the depth-first maze carver: sequencer plus datapath
//
//   channel   ports                                            handshake
//   request   req_cmd, req_cell_row, req_cell_col,             start high and busy low
//             req_random_bits
//   response  rsp_event_res, rsp_out_row, rsp_out_col,         rsp_strobe, one cycle,
//             rsp_move_dir, rsp_is_path                        cannot be held off
//
// each request gives at most one response word, registered
// start: sweeps the grid memory to wall, then answers from ST_START_FIN
// step: empty stack or last pop answer from idle; a pop that reloads the top frame from
//   the stack memory adds ST_POP_LD, a blocked try ST_STEP_DEC, a carve ST_STEP_DEC
//   and ST_STEP_MID (two grid writes on one port); read: one registered grid read
// after reset busy stays high while the grid is cleared
// the response side cannot stall, so the response register is simply overwritten
module maze_carver_dfs
   import mcd_pkg::*;
#(
   parameter int MAZE_ROWS = 15,
   parameter int MAZE_COLS = 25
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_cmd,
   input  logic [3:0] req_cell_row,
   input  logic [4:0] req_cell_col,
   input  logic [7:0] req_random_bits,
   output logic       rsp_strobe,
   output logic [2:0] rsp_event_res,
   output logic [3:0] rsp_out_row,
   output logic [4:0] rsp_out_col,
   output logic [1:0] rsp_move_dir,
   output logic       rsp_is_path
);

   ctrl_cmd_type dp_cmd;   // sequencer to datapath
   ctrl_sts_type dp_sts;   // datapath to sequencer

   mcd_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_cmd),
      .sts     (dp_sts),
      .cmd_o   (dp_cmd),
      .busy    (busy)
   );

   mcd_datapath #(
      .MAZE_ROWS (MAZE_ROWS),
      .MAZE_COLS (MAZE_COLS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd_i           (dp_cmd),
      .sts             (dp_sts),
      .req_cell_row    (req_cell_row),
      .req_cell_col    (req_cell_col),
      .req_random_bits (req_random_bits),
      .rsp_strobe      (rsp_strobe),
      .rsp_event_res   (rsp_event_res),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_move_dir    (rsp_move_dir),
      .rsp_is_path     (rsp_is_path)
   );

   // a step on an empty stack answers finished on the next cycle
   a_empty_step: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_cmd == CMD_STEP && dp_sts.level_zero)
      |=> (rsp_strobe && rsp_event_res == EV_FINISHED))
      else $error("empty step did not report finished");

   // a carve always opens the cell in between on the following cycle
   a_carve_mid: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.carve |=> dp_cmd.mid_write)
      else $error("carve not followed by middle cell write");

   // a read gives its reply through ST_READ_RSP and the response register after acceptance
   a_read_reply: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_cmd == CMD_READ)
      |=> ##1 (rsp_strobe && rsp_event_res == EV_READ))
      else $error("read reply missing");

   // open-path flag only on read replies
   a_path_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_is_path) |-> (rsp_event_res == EV_READ))
      else $error("path flag on non-read word");

endmodule

/* rtl/mcd_ctrl.sv */
// sequencer for the maze carver: decodes items and steps the datapath
module mcd_ctrl
   import mcd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [1:0]   req_cmd,
   input  ctrl_sts_type sts,
   output ctrl_cmd_type cmd_o,
   output logic         busy
);

   state_type state_ff, state_in;
   cmd_type   cmd_dec;

   assign cmd_dec = cmd_type'(req_cmd);
   assign busy    = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT_CLR: begin
            if (sts.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               case (cmd_dec)
                  CMD_START: state_in = ST_START_CLR;
                  CMD_STEP: begin
                     if (sts.level_zero) begin
                        state_in = ST_IDLE;
                     end else if (sts.top_done) begin
                        state_in = sts.pop_more ? ST_POP_LD : ST_IDLE;
                     end else begin
                        state_in = ST_STEP_DEC;
                     end
                  end
                  CMD_READ: state_in = ST_READ_RSP;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_START_CLR: begin
            if (sts.clr_last) state_in = ST_START_FIN;
         end
         ST_START_FIN: state_in = ST_IDLE;
         ST_STEP_DEC:  state_in = sts.step_ok ? ST_STEP_MID : ST_IDLE;
         ST_STEP_MID:  state_in = ST_IDLE;
         ST_POP_LD:    state_in = ST_IDLE;
         ST_READ_RSP:  state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd_o     = '0;
      cmd_o.ev  = EV_STARTED;
      cmd_o.pos = POS_REQ;
      case (state_ff)
         ST_INIT_CLR: cmd_o.clr_write = 1'b1;
         ST_IDLE: begin
            cmd_o.latch_req = 1'b1;
            cmd_o.rd_req    = (cmd_dec == CMD_READ);
            if (start) begin
               case (cmd_dec)
                  CMD_START: cmd_o.clr_reset = 1'b1;
                  CMD_STEP: begin
                     if (sts.level_zero) begin
                        cmd_o.emit = 1'b1;
                        cmd_o.ev   = EV_FINISHED;
                        cmd_o.pos  = POS_ZERO;
                     end else if (sts.top_done) begin
                        cmd_o.pop  = 1'b1;
                        cmd_o.emit = 1'b1;
                        cmd_o.ev   = EV_BACKTRACKED;
                        cmd_o.pos  = POS_TOP;
                     end
                  end
                  default: cmd_o.emit = 1'b0;
               endcase
            end
         end
         ST_START_CLR: cmd_o.clr_write = 1'b1;
         ST_START_FIN: begin
            cmd_o.emit = 1'b1;
            cmd_o.pos  = POS_REQ;
            if (sts.start_inside) begin
               cmd_o.start_open = 1'b1;
               cmd_o.ev         = EV_STARTED;
            end else begin
               cmd_o.start_empty = 1'b1;
               cmd_o.ev          = EV_FINISHED;
            end
         end
         ST_STEP_DEC: begin
            cmd_o.emit = 1'b1;
            if (sts.step_ok) begin
               cmd_o.carve = 1'b1;
               cmd_o.ev    = EV_CARVED;
               cmd_o.pos   = POS_TGT;
            end else begin
               cmd_o.blocked = 1'b1;
               cmd_o.ev      = EV_BLOCKED;
               cmd_o.pos     = POS_TOP;
            end
         end
         ST_STEP_MID: cmd_o.mid_write = 1'b1;
         ST_POP_LD:   cmd_o.pop_load  = 1'b1;
         ST_READ_RSP: begin
            cmd_o.emit = 1'b1;
            cmd_o.ev   = EV_READ;
            cmd_o.pos  = POS_REQ;
         end
         default: cmd_o.emit = 1'b0;
      endcase
   end

endmodule

/* rtl/mcd_datapath.sv */
// maze carver datapath: grid memory, frame stack, top frame and result word
module mcd_datapath
   import mcd_pkg::*;
#(
   parameter int MAZE_ROWS = 15,
   parameter int MAZE_COLS = 25
) (
   input  logic         clock,
   input  logic         reset,
   input  ctrl_cmd_type cmd_i,
   output ctrl_sts_type sts,
   input  logic [3:0]   req_cell_row,
   input  logic [4:0]   req_cell_col,
   input  logic [7:0]   req_random_bits,
   output logic         rsp_strobe,
   output logic [2:0]   rsp_event_res,
   output logic [3:0]   rsp_out_row,
   output logic [4:0]   rsp_out_col,
   output logic [1:0]   rsp_move_dir,
   output logic         rsp_is_path
);

   localparam int CELLS       = MAZE_ROWS * MAZE_COLS;
   localparam int GA_W        = $clog2(CELLS);
   localparam int RW          = $clog2(MAZE_ROWS);
   localparam int CW          = $clog2(MAZE_COLS);
   localparam int FRAME_DEPTH = ((MAZE_ROWS + 1) / 2) * ((MAZE_COLS + 1) / 2);
   localparam int SA_W        = $clog2(FRAME_DEPTH);
   localparam int LVL_W       = $clog2(FRAME_DEPTH + 1);
   localparam int FW          = RW + CW + 8 + 3;
   localparam logic [RW:0] ROW_LIM = (RW + 1)'(MAZE_ROWS);
   localparam logic [CW:0] COL_LIM = (CW + 1)'(MAZE_COLS);

   function automatic logic [GA_W-1:0] cell_addr(input int r, input int c);
      return GA_W'(r * MAZE_COLS + c);
   endfunction

   // memories
   logic          grid_mem  [CELLS];
   logic [FW-1:0] stack_mem [FRAME_DEPTH];
   logic          grid_q_ff;
   logic [FW-1:0] stack_q_ff;

   // registers
   logic [3:0]       req_row_ff, req_row_in;
   logic [4:0]       req_col_ff, req_col_in;
   logic [7:0]       req_bits_ff, req_bits_in;
   logic             req_inside_ff, req_inside_in;
   logic [LVL_W-1:0] level_ff, level_in;
   logic [RW-1:0]    top_row_ff, top_row_in;
   logic [CW-1:0]    top_col_ff, top_col_in;
   logic [7:0]       top_order_ff, top_order_in;
   logic [2:0]       top_next_ff, top_next_in;
   logic [GA_W-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [GA_W-1:0]  mid_addr_ff, mid_addr_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   logic [2:0]       rsp_event_ff, rsp_event_in;
   logic [3:0]       rsp_row_ff, rsp_row_in;
   logic [4:0]       rsp_col_ff, rsp_col_in;
   logic [1:0]       rsp_dir_ff, rsp_dir_in;
   logic             rsp_path_ff, rsp_path_in;

   // combinational
   logic            port_inside;
   logic [GA_W-1:0] port_addr;
   dir_type         dir;
   logic            tgt_ok;
   logic [RW-1:0]   tgt_row, mid_row;
   logic [CW-1:0]   tgt_col, mid_col;
   logic [GA_W-1:0] tgt_addr, mid_addr;
   logic            stack_full;
   logic [7:0]      new_order;
   logic            grid_we, grid_wd;
   logic [GA_W-1:0] grid_wa, grid_ra;
   logic [SA_W-1:0] stack_wa, stack_ra;

   assign port_inside = (32'(req_cell_row) < MAZE_ROWS) && (32'(req_cell_col) < MAZE_COLS);
   assign port_addr   = port_inside ?
                        cell_addr(int'(req_cell_row), int'(req_cell_col)) : '0;

   assign dir        = dir_type'(top_order_ff[{top_next_ff[1:0], 1'b0} +: 2]);
   assign stack_full = (level_ff == LVL_W'(FRAME_DEPTH));
   assign new_order  = shuffle_order(req_bits_ff);

   // two-cell move and the cell in between
   always_comb begin
      tgt_ok  = 1'b0;
      tgt_row = top_row_ff;
      tgt_col = top_col_ff;
      mid_row = top_row_ff;
      mid_col = top_col_ff;
      case (dir)
         DIR_UP: begin
            tgt_ok  = (top_row_ff >= RW'(2));
            tgt_row = top_row_ff - RW'(2);
            mid_row = top_row_ff - RW'(1);
         end
         DIR_DOWN: begin
            tgt_ok  = (({1'b0, top_row_ff} + (RW + 1)'(2)) < ROW_LIM);
            tgt_row = top_row_ff + RW'(2);
            mid_row = top_row_ff + RW'(1);
         end
         DIR_LEFT: begin
            tgt_ok  = (top_col_ff >= CW'(2));
            tgt_col = top_col_ff - CW'(2);
            mid_col = top_col_ff - CW'(1);
         end
         DIR_RIGHT: begin
            tgt_ok  = (({1'b0, top_col_ff} + (CW + 1)'(2)) < COL_LIM);
            tgt_col = top_col_ff + CW'(2);
            mid_col = top_col_ff + CW'(1);
         end
         default: tgt_ok = 1'b0;
      endcase
   end

   assign tgt_addr = tgt_ok ? cell_addr(int'(tgt_row), int'(tgt_col)) : '0;
   assign mid_addr = cell_addr(int'(mid_row), int'(mid_col));

   // grid port selection
   always_comb begin
      grid_we = 1'b0;
      grid_wd = 1'b0;
      grid_wa = '0;
      if (cmd_i.clr_write) begin
         grid_we = 1'b1;
         grid_wa = clr_cnt_ff;
      end else if (cmd_i.start_open) begin
         grid_we = 1'b1;
         grid_wd = 1'b1;
         grid_wa = cell_addr(int'(req_row_ff), int'(req_col_ff));
      end else if (cmd_i.carve) begin
         grid_we = 1'b1;
         grid_wd = 1'b1;
         grid_wa = tgt_addr;
      end else if (cmd_i.mid_write) begin
         grid_we = 1'b1;
         grid_wd = 1'b1;
         grid_wa = mid_addr_ff;
      end
   end

   assign grid_ra  = cmd_i.rd_req ? port_addr : tgt_addr;
   assign stack_wa = SA_W'(level_ff - LVL_W'(1));
   assign stack_ra = SA_W'(level_ff - LVL_W'(2));

   always_ff @(posedge clock) begin
      if (grid_we) grid_mem[grid_wa] <= grid_wd;
      grid_q_ff <= grid_mem[grid_ra];
   end

   always_ff @(posedge clock) begin
      if (cmd_i.carve) begin
         stack_mem[stack_wa] <= {top_row_ff, top_col_ff, top_order_ff, top_next_ff + 3'd1};
      end
      stack_q_ff <= stack_mem[stack_ra];
   end

   // next values
   always_comb begin
      req_row_in    = req_row_ff;
      req_col_in    = req_col_ff;
      req_bits_in   = req_bits_ff;
      req_inside_in = req_inside_ff;
      if (cmd_i.latch_req) begin
         req_row_in    = req_cell_row;
         req_col_in    = req_cell_col;
         req_bits_in   = req_random_bits;
         req_inside_in = port_inside;
      end
   end

   always_comb begin
      level_in = level_ff;
      if (cmd_i.start_open)       level_in = LVL_W'(1);
      else if (cmd_i.start_empty) level_in = '0;
      else if (cmd_i.carve)       level_in = level_ff + LVL_W'(1);
      else if (cmd_i.pop)         level_in = level_ff - LVL_W'(1);
   end

   always_comb begin
      top_row_in   = top_row_ff;
      top_col_in   = top_col_ff;
      top_order_in = top_order_ff;
      top_next_in  = top_next_ff;
      if (cmd_i.start_open) begin
         top_row_in   = RW'(req_row_ff);
         top_col_in   = CW'(req_col_ff);
         top_order_in = new_order;
         top_next_in  = '0;
      end else if (cmd_i.carve) begin
         top_row_in   = tgt_row;
         top_col_in   = tgt_col;
         top_order_in = new_order;
         top_next_in  = '0;
      end else if (cmd_i.blocked) begin
         top_next_in = top_next_ff + 3'd1;
      end else if (cmd_i.pop_load) begin
         {top_row_in, top_col_in, top_order_in, top_next_in} = stack_q_ff;
      end
   end

   always_comb begin
      clr_cnt_in = clr_cnt_ff;
      if (cmd_i.clr_reset)      clr_cnt_in = '0;
      else if (cmd_i.clr_write) clr_cnt_in = clr_cnt_ff + GA_W'(1);
   end

   assign mid_addr_in = cmd_i.carve ? mid_addr : mid_addr_ff;

   // result word
   always_comb begin
      rsp_strobe_in = cmd_i.emit;
      rsp_event_in  = rsp_event_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_dir_in    = rsp_dir_ff;
      rsp_path_in   = rsp_path_ff;
      if (cmd_i.emit) begin
         rsp_event_in = cmd_i.ev;
         case (cmd_i.pos)
            POS_REQ: begin
               rsp_row_in = req_row_ff;
               rsp_col_in = req_col_ff;
            end
            POS_TOP: begin
               rsp_row_in = 4'(top_row_ff);
               rsp_col_in = 5'(top_col_ff);
            end
            POS_TGT: begin
               rsp_row_in = 4'(tgt_row);
               rsp_col_in = 5'(tgt_col);
            end
            default: begin
               rsp_row_in = '0;
               rsp_col_in = '0;
            end
         endcase
         rsp_dir_in  = (cmd_i.ev == EV_CARVED || cmd_i.ev == EV_BLOCKED) ? dir : 2'd0;
         rsp_path_in = (cmd_i.ev == EV_READ) && req_inside_ff && grid_q_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff      <= '0;
         clr_cnt_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         level_ff      <= level_in;
         clr_cnt_ff    <= clr_cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_row_ff    <= req_row_in;
      req_col_ff    <= req_col_in;
      req_bits_ff   <= req_bits_in;
      req_inside_ff <= req_inside_in;
      top_row_ff    <= top_row_in;
      top_col_ff    <= top_col_in;
      top_order_ff  <= top_order_in;
      top_next_ff   <= top_next_in;
      mid_addr_ff   <= mid_addr_in;
      rsp_event_ff  <= rsp_event_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_dir_ff    <= rsp_dir_in;
      rsp_path_ff   <= rsp_path_in;
   end

   assign sts.level_zero   = (level_ff == '0);
   assign sts.top_done     = top_next_ff[2];
   assign sts.pop_more     = (level_ff > LVL_W'(1));
   assign sts.step_ok      = tgt_ok && !grid_q_ff && !stack_full;
   assign sts.clr_last     = (clr_cnt_ff == GA_W'(CELLS - 1));
   assign sts.start_inside = req_inside_ff;

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_event_res = rsp_event_ff;
   assign rsp_out_row   = rsp_row_ff;
   assign rsp_out_col   = rsp_col_ff;
   assign rsp_move_dir  = rsp_dir_ff;
   assign rsp_is_path   = rsp_path_ff;

endmodule
